/* rtl/tsvp_pkg.sv */
// Shared types, constants and header byte function for the TS video packetizer.
`timescale 1ns / 1ps
`default_nettype none
package tsvp_pkg;

    localparam int STORE_DEPTH = 184;
    localparam int KEY_CAP     = 176;
    localparam int PKT_LAST    = 187;
    localparam int HDR_LEN     = 14;
    localparam int MEM_DEPTH   = 2 * STORE_DEPTH;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int DIG_W       = 16;
    localparam int DIG_LAST    = 7;
    localparam int RECIP_SH    = 36;

    localparam logic [12:0] PID_RESET  = 13'd256;
    localparam logic [6:0]  STAMP_MUL  = 7'd90;
    localparam logic [9:0]  DIVISOR    = 10'd1000;
    // ceil(2^36 / 1000), exact for dividends below 2^26
    localparam logic [26:0] RECIP      = 27'd68719477;
    localparam logic [7:0]  SYNC_BYTE  = 8'h47;
    localparam logic [7:0]  FILL_BYTE  = 8'hFF;
    localparam logic [7:0]  AF_FLAGS   = 8'h50;
    localparam logic [7:0]  PCR_TAIL   = 8'h7E;
    localparam logic [7:0]  AF_BASE    = 8'd7;
    localparam logic [3:0]  AFC_BOTH   = 4'h3;
    localparam logic [3:0]  AFC_PAYLD  = 4'h1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_unit;
        logic        last_of_unit;
        logic [47:0] stamp_us;
        logic        keyframe;
    } item_t;

    typedef struct packed {
        logic [63:0] out_word;
        logic [3:0]  out_bytes;
        logic        end_of_packet;
    } result_t;

    // One finished packet waiting for emission
    typedef struct packed {
        logic        bank;
        logic [7:0]  count;
        logic        pusi;
        logic        key;
        logic [32:0] base;
    } desc_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    // PES header byte at position idx, carrying PTS t
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [32:0] t);
        logic [7:0] b;
        case (idx)
            4'd2:    b = 8'h01;
            4'd3:    b = 8'hE0;
            4'd6:    b = 8'h84;
            4'd7:    b = 8'h80;
            4'd8:    b = 8'h05;
            4'd9:    b = {4'h2, t[32:30], 1'b1};
            4'd10:   b = t[29:22];
            4'd11:   b = {t[21:15], 1'b1};
            4'd12:   b = t[14:7];
            4'd13:   b = {t[6:0], 1'b1};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* rtl/tsvp_queue.sv */
// Two-entry descriptor queue between the fill side and the emit side.
`timescale 1ns / 1ps
`default_nettype none
module tsvp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  tsvp_pkg::desc_t     push_desc,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output tsvp_pkg::desc_t     head
);
    import tsvp_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
            count_next  = count_next + 2'd1;
        end
        if (pop && valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            count_next  = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule
`default_nettype wire

/* rtl/tsvp_front.sv */
// Fill side: takes bytes, converts the timestamp, writes PES header and payload.
`timescale 1ns / 1ps
`default_nettype none
module tsvp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  tsvp_pkg::item_t     item,
    output tsvp_pkg::wr_t       wr,
    output logic                push,
    output tsvp_pkg::desc_t     push_desc,
    input  wire logic           q_full,
    input  tsvp_pkg::rel_t      rel
);
    import tsvp_pkg::*;

    localparam logic [2:0] F_RUN  = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_DIV  = 3'd2;
    localparam logic [2:0] F_HDR  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [7:0]        fill_reg, fill_next;
    logic              first_reg, first_next;
    logic              key_reg, key_next;
    logic [32:0]       base_reg, base_next;
    logic [1:0]        busy_reg, busy_next;
    logic [7:0]        held_reg, held_next;
    logic              held_last_reg, held_last_next;
    logic [63:0]       num_reg, num_next;
    logic [47:0]       quo_reg, quo_next;
    logic [9:0]        rem_reg, rem_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [2:0]        cnt_reg, cnt_next;

    logic        accept;
    logic [25:0] div_v;
    logic [52:0] div_p;
    logic [25:0] div_m;
    logic [25:0] div_r;
    logic [7:0]  cap;
    logic [7:0]  fill_inc;

    assign item_stall = !((state_reg == F_RUN) && !busy_reg[bank_reg]);
    assign accept     = item_valid && !item_stall;
    // one 16-bit digit of the divide by 1000: quotient by reciprocal, then remainder
    assign div_v      = {rem_reg, num_reg[63:48]};
    assign div_p      = 53'(div_v) * 53'(RECIP);
    assign div_m      = 26'(dig_reg) * 26'(DIVISOR);
    assign div_r      = div_v - div_m;
    assign cap        = (first_reg && key_reg) ? 8'(KEY_CAP) : 8'(STORE_DEPTH);
    assign fill_inc   = fill_reg + 8'd1;

    assign push              = (state_reg == F_PUSH) && !q_full;
    assign push_desc.bank    = bank_reg;
    assign push_desc.count   = fill_reg;
    assign push_desc.pusi    = first_reg;
    assign push_desc.key     = first_reg && key_reg;
    assign push_desc.base    = base_reg;

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        fill_next      = fill_reg;
        first_next     = first_reg;
        key_next       = key_reg;
        base_next      = base_reg;
        busy_next      = busy_reg;
        held_next      = held_reg;
        held_last_next = held_last_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        wr.en          = 1'b0;
        wr.addr        = MEM_AW'(fill_reg) + (bank_reg ? MEM_AW'(STORE_DEPTH) : '0);
        wr.data        = item.data_byte;

        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        case (state_reg)
            F_RUN:
            begin
                if (accept)
                begin
                    if (item.first_of_unit)
                    begin
                        held_next      = item.data_byte;
                        held_last_next = item.last_of_unit;
                        key_next       = item.keyframe;
                        first_next     = 1'b1;
                        num_next       = 64'(item.stamp_us) * 64'(STAMP_MUL);
                        state_next     = F_MUL;
                    end
                    else
                    begin
                        wr.en     = 1'b1;
                        fill_next = fill_inc;
                        if (fill_inc >= cap || item.last_of_unit)
                        begin
                            state_next = F_PUSH;
                        end
                    end
                end
            end
            F_MUL:
            begin
                rem_next   = '0;
                cnt_next   = '0;
                state_next = F_DIV;
            end
            F_DIV:
            begin
                // four digits from the top, each a quotient step then a remainder step
                cnt_next = cnt_reg + 3'd1;
                if (!cnt_reg[0])
                begin
                    dig_next = div_p[RECIP_SH +: DIG_W];
                end
                else
                begin
                    rem_next = div_r[9:0];
                    quo_next = {quo_reg[31:0], dig_reg};
                    num_next = {num_reg[47:0], 16'h0000};
                    if (cnt_reg == 3'(DIG_LAST))
                    begin
                        base_next  = quo_next[32:0];
                        fill_next  = '0;
                        state_next = F_HDR;
                    end
                end
            end
            F_HDR:
            begin
                wr.en     = 1'b1;
                fill_next = fill_inc;
                if (fill_reg == 8'(HDR_LEN))
                begin
                    wr.data    = held_reg;
                    state_next = held_last_reg ? F_PUSH : F_RUN;
                end
                else
                begin
                    wr.data = hdr_byte(fill_reg[3:0], base_reg);
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                    fill_next           = '0;
                    first_next          = 1'b0;
                    state_next          = F_RUN;
                end
            end
            default:
            begin
                state_next = F_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_RUN;
            bank_reg  <= 1'b0;
            fill_reg  <= '0;
            first_reg <= 1'b0;
            key_reg   <= 1'b0;
            base_reg  <= '0;
            busy_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            fill_reg  <= fill_next;
            first_reg <= first_next;
            key_reg   <= key_next;
            base_reg  <= base_next;
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        held_last_reg <= held_last_next;
        num_reg       <= num_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dig_reg       <= dig_next;
    end

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !busy_reg[bank_reg])
        else $error("write into a bank still being emitted");

    a_push_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> busy_reg[$past(bank_reg)] && (bank_reg != $past(bank_reg)))
        else $error("pushed bank not marked busy or bank not swapped");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fill_reg != 8'd0) && (fill_reg <= 8'(STORE_DEPTH)))
        else $error("packet length out of range");

endmodule
`default_nettype wire

/* rtl/tsvp_back.sv */
// Emit side: holds the packet stores and builds 188-byte packets as 8-byte words.
`timescale 1ns / 1ps
`default_nettype none
module tsvp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  tsvp_pkg::wr_t       wr,
    input  wire logic           q_valid,
    input  tsvp_pkg::desc_t     q_head,
    output logic                pop,
    output tsvp_pkg::rel_t      rel,
    input  wire logic [12:0]    video_pid,
    output logic                result_valid,
    input  wire logic           result_stall,
    output tsvp_pkg::result_t   result
);
    import tsvp_pkg::*;

    logic [7:0] mem [MEM_DEPTH];

    // stage A: packet byte position
    logic        a_v_reg;
    logic [7:0]  p_reg;
    desc_t       d_reg;
    logic [7:0]  start_reg;
    logic [7:0]  len_reg;
    logic [7:0]  b3_reg;
    logic [3:0]  cc_reg;

    // stage B: byte on its way into the word
    logic        b_v_reg;
    logic        b_mem_reg;
    logic [7:0]  b_const_reg;
    logic [2:0]  b_k_reg;
    logic        b_wend_reg;
    logic        b_last_reg;
    logic [7:0]  rd_reg;

    logic [63:0] asm_reg;
    logic        asm_full_reg;
    logic        asm_eop_reg;
    result_t     out_reg;
    logic        out_v_reg;

    logic              out_free;
    logic              adv;
    logic              a_mem;
    logic [7:0]        a_const;
    logic [7:0]        off;
    logic [MEM_AW-1:0] rd_addr;
    logic [7:0]        pad;
    logic [7:0]        stuff;
    logic [63:0]       asm_ins;
    logic [7:0]        b_byte;
    logic [32:0]       t;

    assign out_free     = !out_v_reg || !result_stall;
    assign adv          = !asm_full_reg || out_free;
    assign pop          = !a_v_reg && q_valid;
    assign rel.en       = a_v_reg && adv && (p_reg == 8'(PKT_LAST));
    assign rel.bank     = d_reg.bank;
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    assign pad   = 8'(KEY_CAP) - q_head.count;
    assign stuff = 8'(STORE_DEPTH) - q_head.count;
    assign t     = d_reg.base;
    assign off   = p_reg - start_reg;
    assign rd_addr = MEM_AW'(off) + (d_reg.bank ? MEM_AW'(STORE_DEPTH) : '0);
    assign a_mem = (p_reg >= start_reg);

    always_comb
    begin
        case (p_reg)
            8'd0:    a_const = SYNC_BYTE;
            8'd1:    a_const = {1'b0, d_reg.pusi, 1'b0, video_pid[12:8]};
            8'd2:    a_const = video_pid[7:0];
            8'd3:    a_const = b3_reg;
            8'd4:    a_const = len_reg;
            8'd5:    a_const = d_reg.key ? AF_FLAGS : 8'h00;
            8'd6:    a_const = d_reg.key ? t[32:25] : FILL_BYTE;
            8'd7:    a_const = d_reg.key ? t[24:17] : FILL_BYTE;
            8'd8:    a_const = d_reg.key ? t[16:9] : FILL_BYTE;
            8'd9:    a_const = d_reg.key ? t[8:1] : FILL_BYTE;
            8'd10:   a_const = d_reg.key ? {t[0], PCR_TAIL[6:0]} : FILL_BYTE;
            8'd11:   a_const = d_reg.key ? 8'h00 : FILL_BYTE;
            default: a_const = FILL_BYTE;
        endcase
    end

    // Stage A: take a descriptor and walk the 188 byte positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            p_reg   <= '0;
            cc_reg  <= '0;
        end
        else if (pop)
        begin
            a_v_reg <= 1'b1;
            p_reg   <= '0;
            cc_reg  <= cc_reg + 4'd1;
        end
        else if (a_v_reg && adv)
        begin
            if (p_reg == 8'(PKT_LAST))
            begin
                a_v_reg <= 1'b0;
            end
            else
            begin
                p_reg <= p_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            d_reg <= q_head;
            if (q_head.key)
            begin
                start_reg <= 8'd12 + pad;
                len_reg   <= AF_BASE + pad;
                b3_reg    <= {AFC_BOTH, cc_reg};
            end
            else if (q_head.count < 8'(STORE_DEPTH))
            begin
                start_reg <= 8'd4 + stuff;
                len_reg   <= stuff - 8'd1;
                b3_reg    <= {AFC_BOTH, cc_reg};
            end
            else
            begin
                start_reg <= 8'd4;
                len_reg   <= FILL_BYTE;
                b3_reg    <= {AFC_PAYLD, cc_reg};
            end
        end
    end

    // Packet stores: two banks, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (adv && a_v_reg && a_mem)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_mem_reg   <= a_mem;
            b_const_reg <= a_const;
            b_k_reg     <= p_reg[2:0];
            b_wend_reg  <= (p_reg[2:0] == 3'd7) || (p_reg == 8'(PKT_LAST));
            b_last_reg  <= (p_reg == 8'(PKT_LAST));
        end
    end

    // Word assembly, left aligned; a new word starts cleared
    assign b_byte = b_mem_reg ? rd_reg : b_const_reg;

    always_comb
    begin
        asm_ins = (b_k_reg == 3'd0) ? 64'd0 : asm_reg;
        asm_ins[{~b_k_reg, 3'b000} +: 8] = b_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_full_reg <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (asm_full_reg && out_free)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_v_reg <= 1'b0;
            end
            if (adv && b_v_reg && b_wend_reg)
            begin
                asm_full_reg <= 1'b1;
            end
            else if (asm_full_reg && out_free)
            begin
                asm_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (asm_full_reg && out_free)
        begin
            out_reg.out_word      <= asm_reg;
            out_reg.out_bytes     <= asm_eop_reg ? 4'd4 : 4'd8;
            out_reg.end_of_packet <= asm_eop_reg;
        end
        if (adv && b_v_reg)
        begin
            asm_reg     <= asm_ins;
            asm_eop_reg <= b_last_reg;
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> a_v_reg && (p_reg == 8'd0))
        else $error("descriptor taken while a packet is in progress");

    a_cc_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> cc_reg == 4'($past(cc_reg) + 4'd1))
        else $error("continuity counter did not advance per packet");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        asm_full_reg && !out_free |=> asm_full_reg && $stable(asm_reg))
        else $error("assembled word lost while output stalled");

endmodule
`default_nettype wire

/* rtl/mpeg_ts_video_packetizer.sv */
// Top level of the MPEG-2 TS video packetizer.
`timescale 1ns / 1ps
`default_nettype none
// Takes access unit bytes one per transfer and emits 188-byte transport packets
// as 24 eight-byte words (four bytes on the last word, end_of_packet set).
// A plain payload byte goes straight into the packet store. The first byte of a
// unit holds the input through F_MUL, F_DIV, the divide by 1000 of the times-90
// product that yields the 90 kHz PTS (four 16-bit digits, each a reciprocal
// multiply and a remainder step), and F_HDR, which writes the PES header and then
// the byte; F_PUSH hands a completed packet over. Two 184-byte packet stores
// alternate, so filling one overlaps emission of the other; emission walks one
// packet byte position per cycle unless output stalls, and input stalls when
// both stores hold packets. video_pid resets to 256; the user must write it
// through pid_we/pid_data only while idle, which the block does not enforce.
module mpeg_ts_video_packetizer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pid_we,
    input  wire logic [12:0]    pid_data,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  tsvp_pkg::item_t     item,
    output logic                result_valid,
    input  wire logic           result_stall,
    output tsvp_pkg::result_t   result
);
    import tsvp_pkg::*;

    logic [12:0] video_pid_reg;
    wr_t         wr;
    rel_t        rel;
    desc_t       push_desc;
    desc_t       q_head;
    logic        push;
    logic        q_full;
    logic        q_valid;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_pid_reg <= PID_RESET;
        end
        else if (pid_we)
        begin
            video_pid_reg <= pid_data;
        end
    end

    tsvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .wr         (wr),
        .push       (push),
        .push_desc  (push_desc),
        .q_full     (q_full),
        .rel        (rel)
    );

    tsvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    tsvp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .rel          (rel),
        .video_pid    (video_pid_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
